[src/bba_pkg.sv]
`timescale 1ns / 1ps
// bba_pkg: shared types and codes for the buddy block allocator.
// Used by buddy_block_allocator_top; no dependencies.
package bba_pkg;

   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_INIT  = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ZERO     = 3'd1;
   localparam logic [2:0] ST_TOO_BIG  = 3'd2;
   localparam logic [2:0] ST_NO_BLOCK = 3'd3;
   localparam logic [2:0] ST_BAD_FREE = 3'd4;

   localparam logic CSR_POOL_LEVELS  = 1'b0;
   localparam logic CSR_BASE_ADDRESS = 1'b1;

   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 3;
   localparam int LEVEL_W  = 4;

   typedef enum logic [4:0] {
      S_BOOT,
      S_IDLE,
      S_INIT,
      S_SIZE,
      S_SRD,
      S_SCHK,
      S_SPRD,
      S_SPWR,
      S_AMRD,
      S_AMWR,
      S_FRD,
      S_FCHK,
      S_MRD,
      S_MCHK,
      S_FSRD,
      S_FSWR,
      S_RESP
   } state_type;

endpackage

[src/buddy_block_allocator_top.sv]
`timescale 1ns / 1ps
// Buddy block allocator: free-bit tree and allocation marks in on-chip memories.
// Depends on bba_pkg.
// One request is worked at a time; where a memory step reads and then writes,
// the write follows in the cycle after the read. Allocate steps through the
// size levels, scans 32-bit free-tree words, splits the found block level by
// level, marks the block and posts the result. Free checks the mark, merges
// level by level, sets the final block and posts. Initialize resets the tree
// to one free top block. After reset a boot state comes before the first beat.
// The result register lets a new request start while a result waits.
module buddy_block_allocator_top #(
   parameter int MAX_LEVELS_BUILT = 11,
   parameter int MIN_BLOCK_LOG2   = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // request_bytes[31:0], free_address[63:32]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // block_address[31:0], block_level[35:32]
   output logic [2:0]  rsp_tuser,   // status[2:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int LW  = $clog2(MAX_LEVELS_BUILT);
   localparam int NW  = MAX_LEVELS_BUILT;
   localparam int NB  = MAX_LEVELS_BUILT - 1;
   localparam int TW  = (MAX_LEVELS_BUILT - 1 < 5) ? MAX_LEVELS_BUILT - 1 : 5;
   localparam int TA  = NW - TW;
   localparam int TWD = 1 << TW;
   localparam int TWN = 1 << TA;
   localparam int AWL = (MAX_LEVELS_BUILT - 2 < 5) ? MAX_LEVELS_BUILT - 2 : 5;
   localparam int AA  = NB - AWL;
   localparam int AWD = 1 << AWL;
   localparam int AWN = 1 << AA;
   localparam int MBN = 1 << NB;
   localparam int SZW = MIN_BLOCK_LOG2 + MAX_LEVELS_BUILT;
   localparam int CW  = (SZW > 32) ? SZW : 32;

   bba_pkg::state_type state_ff, state_in;

   logic [3:0]        pool_levels_ff;
   logic [31:0]       base_ff;
   logic [LW-1:0]     lev_ff, lev_in;
   logic [LW-1:0]     f_ff, f_in;
   logic [TA-1:0]     w_ff, w_in;
   logic [NB-1:0]     idx_ff, idx_in;
   logic [NW-1:0]     node_ff, node_in;
   logic [NB-1:0]     mb_ff, mb_in;
   logic [31:0]       nbytes_ff, nbytes_in;
   logic [31:0]       faddr_ff, faddr_in;
   logic [CW-1:0]     size_ff, size_in;
   logic [2:0]        res_st_ff, res_st_in;
   logic [31:0]       res_addr_ff, res_addr_in;
   logic [LW-1:0]     res_lvl_ff, res_lvl_in;
   logic              rsp_valid_ff;
   logic [2:0]        rsp_st_ff;
   logic [31:0]       rsp_addr_ff;
   logic [LW-1:0]     rsp_lvl_ff;

   logic [TWD-1:0]    tree_mem [TWN];
   logic [TWN-1:0]    tv_ff;
   logic [TWD-1:0]    tree_q_ff;
   logic              tree_qv_ff;
   logic              t_re, t_we;
   logic [TA-1:0]     t_raddr, t_waddr;
   logic [TWD-1:0]    t_wdata;

   logic [AWD-1:0]    amark_mem [AWN];
   logic [AWN-1:0]    av_ff;
   logic [AWD-1:0]    amark_q_ff;
   logic              amark_qv_ff;
   logic [LW-1:0]     alvl_mem [MBN];
   logic [LW-1:0]     alvl_q_ff;
   logic              a_re, a_we, l_we;
   logic [AA-1:0]     a_raddr, a_waddr;
   logic [AWD-1:0]    a_wdata;
   logic [NB-1:0]     a_rmb;

   logic              req_fire, csr_fire, can_load, clear_all;
   logic [LW-1:0]     top_c;
   logic [TWD-1:0]    t_data;
   logic [AWD-1:0]    a_data, a_mask;
   logic [TWD-1:0]    node_bit;
   logic              size_lt;
   logic [NW-1:0]     base_f;
   logic [NW:0]       end_f;
   logic [TA-1:0]     end_word;
   logic [TWD-1:0]    in_range, hits;
   logic              hit_any;
   logic [TW-1:0]     hit_pos;
   logic [NW-1:0]     hit_node;
   logic [31:0]       off_c, mblk_c;
   logic              free_bad_c;
   logic [NB-1:0]     mb_c;
   logic [NB-1:0]     mb_idx_c;

   function automatic logic [NW-1:0] base_of(input logic [LW-1:0] f);
      return (NW'(1) << (NW - 1)) >> f;
   endfunction

   function automatic logic [NW-1:0] node_of(input logic [LW-1:0] f,
                                             input logic [NB-1:0] i);
      logic [NW-1:0] b;
      b = base_of(f);
      return b | (NW'(i) & (b - NW'(1)));
   endfunction

   function automatic logic [31:0] addr_of(input logic [31:0] base,
                                           input logic [NB-1:0] mb);
      logic [NB+MIN_BLOCK_LOG2+31:0] x;
      x = {32'd0, mb, {MIN_BLOCK_LOG2{1'b0}}};
      return base + x[31:0];
   endfunction

   assign req_fire  = req_tvalid && req_tready;
   assign csr_fire  = csr_valid && csr_ready;
   assign can_load  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == bba_pkg::S_IDLE);
   assign csr_ready  = (state_ff == bba_pkg::S_IDLE);
   assign clear_all  = req_fire && (req_tuser == bba_pkg::ACT_INIT);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tdata  = {4'd0, 4'(rsp_lvl_ff), rsp_addr_ff};

   always_comb begin
      if (pool_levels_ff == 4'd0) begin
         top_c = '0;
      end else if (int'(pool_levels_ff) > MAX_LEVELS_BUILT) begin
         top_c = LW'(MAX_LEVELS_BUILT - 1);
      end else begin
         top_c = LW'(pool_levels_ff - 4'd1);
      end
   end

   assign t_data   = tree_qv_ff ? tree_q_ff : '0;
   assign a_data   = amark_qv_ff ? amark_q_ff : '0;
   assign a_mask   = AWD'(1) << (mb_ff % AWD);
   assign node_bit = TWD'(1) << node_ff[TW-1:0];
   assign size_lt  = size_ff < CW'(nbytes_ff);
   assign base_f   = base_of(f_ff);
   assign end_f    = (NW+1)'(base_f) + ((NW+1)'(1) << (top_c - f_ff));
   assign end_word = TA'((end_f - (NW+1)'(1)) >> TW);
   assign hit_node = {w_ff, hit_pos};
   assign off_c    = faddr_ff - base_ff;
   assign mblk_c   = off_c >> MIN_BLOCK_LOG2;
   assign free_bad_c = (off_c[MIN_BLOCK_LOG2-1:0] != '0) || ((mblk_c >> top_c) != 32'd0);
   assign mb_c     = NB'(mblk_c);
   assign mb_idx_c = NB'(idx_ff << lev_ff);

   always_comb begin
      logic [NW-1:0] node_p;
      for (int p = 0; p < TWD; p++) begin
         node_p = {w_ff, TW'(p)};
         in_range[p] = ({1'b0, node_p} >= {1'b0, base_f}) && ({1'b0, node_p} < end_f);
      end
      hits = t_data & in_range;
      hit_any = |hits;
      hit_pos = '0;
      for (int p = TWD - 1; p >= 0; p--) begin
         if (hits[p]) begin
            hit_pos = TW'(p);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bba_pkg::S_BOOT: state_in = bba_pkg::S_IDLE;
         bba_pkg::S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  bba_pkg::ACT_ALLOC:
                     state_in = (req_tdata[31:0] == 32'd0) ? bba_pkg::S_RESP : bba_pkg::S_SIZE;
                  bba_pkg::ACT_FREE: state_in = bba_pkg::S_FRD;
                  bba_pkg::ACT_INIT: state_in = bba_pkg::S_INIT;
                  default:           state_in = bba_pkg::S_IDLE;
               endcase
            end
         end
         bba_pkg::S_INIT: state_in = bba_pkg::S_RESP;
         bba_pkg::S_SIZE: begin
            if (!size_lt) begin
               state_in = bba_pkg::S_SRD;
            end else if (lev_ff == top_c) begin
               state_in = bba_pkg::S_RESP;
            end
         end
         bba_pkg::S_SRD: state_in = bba_pkg::S_SCHK;
         bba_pkg::S_SCHK: begin
            if (hit_any) begin
               state_in = (f_ff == lev_ff) ? bba_pkg::S_AMRD : bba_pkg::S_SPRD;
            end else if (w_ff == end_word && f_ff == top_c) begin
               state_in = bba_pkg::S_RESP;
            end else begin
               state_in = bba_pkg::S_SRD;
            end
         end
         bba_pkg::S_SPRD: state_in = bba_pkg::S_SPWR;
         bba_pkg::S_SPWR:
            state_in = (f_ff == lev_ff) ? bba_pkg::S_AMRD : bba_pkg::S_SPRD;
         bba_pkg::S_AMRD: state_in = bba_pkg::S_AMWR;
         bba_pkg::S_AMWR: state_in = bba_pkg::S_RESP;
         bba_pkg::S_FRD:
            state_in = free_bad_c ? bba_pkg::S_RESP : bba_pkg::S_FCHK;
         bba_pkg::S_FCHK: begin
            if (!(|(a_data & a_mask)) || alvl_q_ff > top_c) begin
               state_in = bba_pkg::S_RESP;
            end else if (alvl_q_ff == top_c) begin
               state_in = bba_pkg::S_FSRD;
            end else begin
               state_in = bba_pkg::S_MRD;
            end
         end
         bba_pkg::S_MRD: state_in = bba_pkg::S_MCHK;
         bba_pkg::S_MCHK: begin
            if (|(t_data & node_bit) && LW'(lev_ff + 1'b1) != top_c) begin
               state_in = bba_pkg::S_MRD;
            end else begin
               state_in = bba_pkg::S_FSRD;
            end
         end
         bba_pkg::S_FSRD: state_in = bba_pkg::S_FSWR;
         bba_pkg::S_FSWR: state_in = bba_pkg::S_RESP;
         bba_pkg::S_RESP: begin
            if (can_load) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         default: state_in = bba_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      logic [NW-1:0] nd;
      nd          = '0;
      lev_in      = lev_ff;
      f_in        = f_ff;
      w_in        = w_ff;
      idx_in      = idx_ff;
      node_in     = node_ff;
      mb_in       = mb_ff;
      nbytes_in   = nbytes_ff;
      faddr_in    = faddr_ff;
      size_in     = size_ff;
      res_st_in   = res_st_ff;
      res_addr_in = res_addr_ff;
      res_lvl_in  = res_lvl_ff;
      t_re = 1'b0; t_raddr = '0;
      t_we = 1'b0; t_waddr = '0; t_wdata = '0;
      a_re = 1'b0; a_rmb = '0;
      a_we = 1'b0; a_wdata = '0;
      l_we = 1'b0;
      case (state_ff)
         bba_pkg::S_BOOT, bba_pkg::S_INIT: begin
            nd = base_of(top_c);
            t_we = 1'b1;
            t_waddr = nd[NW-1:TW];
            t_wdata = TWD'(1) << nd[TW-1:0];
            res_st_in = bba_pkg::ST_OK;
            res_addr_in = base_ff;
            res_lvl_in = top_c;
         end
         bba_pkg::S_IDLE: begin
            if (req_fire) begin
               nbytes_in = req_tdata[31:0];
               faddr_in  = req_tdata[63:32];
               lev_in    = '0;
               size_in   = CW'(1) << MIN_BLOCK_LOG2;
               res_st_in = bba_pkg::ST_ZERO;
               res_addr_in = '0;
               res_lvl_in  = '0;
            end
         end
         bba_pkg::S_SIZE: begin
            if (!size_lt) begin
               f_in = lev_ff;
               w_in = TA'(base_of(lev_ff) >> TW);
            end else if (lev_ff == top_c) begin
               res_st_in = bba_pkg::ST_TOO_BIG;
            end else begin
               lev_in  = lev_ff + 1'b1;
               size_in = size_ff << 1;
            end
         end
         bba_pkg::S_SRD: begin
            t_re = 1'b1;
            t_raddr = w_ff;
         end
         bba_pkg::S_SCHK: begin
            if (hit_any) begin
               t_we = 1'b1;
               t_waddr = w_ff;
               t_wdata = t_data & ~(TWD'(1) << hit_pos);
               idx_in = NB'(hit_node - base_f);
            end else if (w_ff == end_word) begin
               if (f_ff == top_c) begin
                  res_st_in = bba_pkg::ST_NO_BLOCK;
               end else begin
                  f_in = f_ff + 1'b1;
                  w_in = TA'(base_of(LW'(f_ff + 1'b1)) >> TW);
               end
            end else begin
               w_in = w_ff + 1'b1;
            end
         end
         bba_pkg::S_SPRD: begin
            nd = node_of(LW'(f_ff - 1'b1), NB'({idx_ff, 1'b1}));
            node_in = nd;
            f_in = f_ff - 1'b1;
            idx_in = NB'({idx_ff, 1'b0});
            t_re = 1'b1;
            t_raddr = nd[NW-1:TW];
         end
         bba_pkg::S_SPWR, bba_pkg::S_FSWR: begin
            t_we = 1'b1;
            t_waddr = node_ff[NW-1:TW];
            t_wdata = t_data | node_bit;
            if (state_ff == bba_pkg::S_FSWR) begin
               res_st_in = bba_pkg::ST_OK;
               res_addr_in = addr_of(base_ff, mb_idx_c);
               res_lvl_in = lev_ff;
            end
         end
         bba_pkg::S_AMRD: begin
            a_re = 1'b1;
            a_rmb = mb_idx_c;
            mb_in = mb_idx_c;
         end
         bba_pkg::S_AMWR: begin
            a_we = 1'b1;
            a_wdata = a_data | a_mask;
            l_we = 1'b1;
            res_st_in = bba_pkg::ST_OK;
            res_addr_in = addr_of(base_ff, mb_ff);
            res_lvl_in = lev_ff;
         end
         bba_pkg::S_FRD: begin
            mb_in = mb_c;
            if (free_bad_c) begin
               res_st_in = bba_pkg::ST_BAD_FREE;
            end else begin
               a_re = 1'b1;
               a_rmb = mb_c;
            end
         end
         bba_pkg::S_FCHK: begin
            if (!(|(a_data & a_mask)) || alvl_q_ff > top_c) begin
               res_st_in = bba_pkg::ST_BAD_FREE;
            end else begin
               a_we = 1'b1;
               a_wdata = a_data & ~a_mask;
               lev_in = alvl_q_ff;
               idx_in = mb_ff >> alvl_q_ff;
            end
         end
         bba_pkg::S_MRD: begin
            nd = node_of(lev_ff, idx_ff ^ NB'(1));
            node_in = nd;
            t_re = 1'b1;
            t_raddr = nd[NW-1:TW];
         end
         bba_pkg::S_MCHK: begin
            if (|(t_data & node_bit)) begin
               t_we = 1'b1;
               t_waddr = node_ff[NW-1:TW];
               t_wdata = t_data & ~node_bit;
               idx_in = idx_ff >> 1;
               lev_in = lev_ff + 1'b1;
            end
         end
         bba_pkg::S_FSRD: begin
            nd = node_of(lev_ff, idx_ff);
            node_in = nd;
            t_re = 1'b1;
            t_raddr = nd[NW-1:TW];
         end
         default: begin
         end
      endcase
      a_raddr = AA'(a_rmb / AWD);
      a_waddr = AA'(mb_ff / AWD);
   end

   // memories
   always_ff @(posedge clock) begin
      if (t_we) begin
         tree_mem[t_waddr] <= t_wdata;
      end
      if (t_re) begin
         tree_q_ff  <= tree_mem[t_raddr];
         tree_qv_ff <= tv_ff[t_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         amark_mem[a_waddr] <= a_wdata;
      end
      if (l_we) begin
         alvl_mem[mb_ff] <= lev_ff;
      end
      if (a_re) begin
         amark_q_ff  <= amark_mem[a_raddr];
         amark_qv_ff <= av_ff[a_raddr];
         alvl_q_ff   <= alvl_mem[a_rmb];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bba_pkg::S_BOOT;
         pool_levels_ff <= 4'd11;
         base_ff        <= '0;
         tv_ff          <= '0;
         av_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_fire) begin
            if (csr_index == bba_pkg::CSR_POOL_LEVELS) begin
               pool_levels_ff <= csr_data[3:0];
            end else begin
               base_ff <= csr_data;
            end
         end
         if (clear_all) begin
            tv_ff <= '0;
            av_ff <= '0;
         end else begin
            if (t_we) begin
               tv_ff[t_waddr] <= 1'b1;
            end
            if (a_we) begin
               av_ff[a_waddr] <= 1'b1;
            end
         end
         if (state_ff == bba_pkg::S_RESP && can_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lev_ff      <= lev_in;
      f_ff        <= f_in;
      w_ff        <= w_in;
      idx_ff      <= idx_in;
      node_ff     <= node_in;
      mb_ff       <= mb_in;
      nbytes_ff   <= nbytes_in;
      faddr_ff    <= faddr_in;
      size_ff     <= size_in;
      res_st_ff   <= res_st_in;
      res_addr_ff <= res_addr_in;
      res_lvl_ff  <= res_lvl_in;
      if (state_ff == bba_pkg::S_RESP && can_load) begin
         rsp_st_ff   <= res_st_ff;
         rsp_addr_ff <= (res_st_ff == bba_pkg::ST_OK) ? res_addr_ff : '0;
         rsp_lvl_ff  <= (res_st_ff == bba_pkg::ST_OK) ? res_lvl_ff : '0;
      end
   end

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != bba_pkg::ST_OK |-> rsp_tdata == '0)
      else $error("error beat carries nonzero address or level");

   a_tree_port: assert property (@(posedge clock) disable iff (reset)
      t_we && t_re |-> t_waddr != t_raddr)
      else $error("free tree read and write hit one word");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == bba_pkg::S_SCHK |-> $past(state_ff) == bba_pkg::S_SRD)
      else $error("scan check without a preceding read");
`endif

endmodule
